// ===== design/bgd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants for the button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int REG_WIDTH   = 16;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG     = 2'd2;

   localparam logic [REG_WIDTH-1:0] DEBOUNCE_RST = 16'd50;
   localparam logic [REG_WIDTH-1:0] DOUBLE_RST   = 16'd300;
   localparam logic [REG_WIDTH-1:0] LONG_RST     = 16'd1000;

   typedef enum logic [1:0] {
      PH_IDLE       = 2'd0,
      PH_DEBOUNCE   = 2'd1,
      PH_PRESSED    = 2'd2,
      PH_CLICK_WAIT = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SINGLE = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } event_type;

   typedef struct packed {
      logic [REG_WIDTH-1:0] debounce_ticks;
      logic [REG_WIDTH-1:0] double_click_ticks;
      logic [REG_WIDTH-1:0] long_press_ticks;
   } cfg_type;

endpackage

// ===== design/bgd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_cfg_regs
// Write-only timing registers; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module bgd_cfg_regs
   import bgd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_WIDTH-1:0] csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks     <= DEBOUNCE_RST;
         cfg_ff.double_click_ticks <= DOUBLE_RST;
         cfg_ff.long_press_ticks   <= LONG_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE: cfg_ff.debounce_ticks     <= csr_wdata;
            CSR_DOUBLE:   cfg_ff.double_click_ticks <= csr_wdata;
            CSR_LONG:     cfg_ff.long_press_ticks   <= csr_wdata;
            default:      ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/bgd_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_fsm
// Phase machine and shared tick counter; one step per enabled cycle.
// ----------------------------------------------------------------------------
module bgd_fsm
   import bgd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      step_en,
   input  logic      level,
   input  cfg_type   cfg,
   output event_type gesture
);

   phase_type              phase_ff, phase_in;
   logic                   long_done_ff, long_done_in;
   logic                   last_level_ff, last_level_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic [COUNT_WIDTH-1:0] count_inc;
   logic [CMP_WIDTH-1:0]   count_cmp;
   logic                   exp_deb, exp_dbl, exp_long;
   logic                   edge_seen;

   // counter advances (saturating) in every timed phase before the compare
   assign count_inc = (phase_ff == PH_IDLE || count_ff == {COUNT_WIDTH{1'b1}}) ?
                      count_ff : count_ff + 1'b1;
   assign count_cmp = CMP_WIDTH'(count_inc);
   assign exp_deb   = count_cmp >= CMP_WIDTH'(cfg.debounce_ticks);
   assign exp_dbl   = count_cmp >= CMP_WIDTH'(cfg.double_click_ticks);
   assign exp_long  = count_cmp >= CMP_WIDTH'(cfg.long_press_ticks);
   assign edge_seen = level != last_level_ff;

   // next state: expiry first, then edge action on the resulting phase
   always_comb begin
      phase_type ph;
      logic      ld;
      logic [COUNT_WIDTH-1:0] cnt;
      ph  = phase_ff;
      ld  = long_done_ff;
      cnt = count_inc;
      unique case (phase_ff)
         PH_DEBOUNCE: begin
            if (exp_deb) begin
               if (!level) begin
                  ph  = PH_PRESSED;
                  ld  = 1'b0;
                  cnt = '0;
               end else begin
                  ph = PH_IDLE;
               end
            end
         end
         PH_PRESSED: begin
            if (!long_done_ff && exp_long) ld = 1'b1;
         end
         PH_CLICK_WAIT: begin
            if (exp_dbl) ph = PH_IDLE;
         end
         default: ;
      endcase
      if (edge_seen) begin
         unique case (ph)
            PH_IDLE: begin
               if (!level) begin
                  ph  = PH_DEBOUNCE;
                  cnt = '0;
               end
            end
            PH_PRESSED: begin
               if (level) begin
                  if (!ld) begin
                     ph  = PH_CLICK_WAIT;
                     cnt = '0;
                  end else begin
                     ph = PH_IDLE;
                  end
               end
            end
            PH_CLICK_WAIT: begin
               if (!level) ph = PH_IDLE;
            end
            default: ;
         endcase
      end
      phase_in      = ph;
      long_done_in  = ld;
      count_in      = cnt;
      last_level_in = level;
   end

   // event for this tick
   always_comb begin
      gesture = EV_NONE;
      unique case (phase_ff)
         PH_PRESSED: begin
            if (!long_done_ff && exp_long) gesture = EV_LONG;
         end
         PH_CLICK_WAIT: begin
            if (exp_dbl)                     gesture = EV_SINGLE;
            else if (edge_seen && !level)    gesture = EV_DOUBLE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         long_done_ff  <= 1'b0;
         last_level_ff <= 1'b1;
         count_ff      <= '0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         long_done_ff  <= long_done_in;
         last_level_ff <= last_level_in;
         count_ff      <= count_in;
      end
   end

endmodule

// ===== design/button_gesture_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_detector_unit
// Debounces an active-low button and reports single click, double click and
// long press, one gesture code per sampled level.
// ----------------------------------------------------------------------------
// Path: the input register takes a sample on transfer; the result register
//          takes its gesture when the held sample steps, waiting while it is full.
// Throughput: one sample per cycle while the output is not stalled; the
//          phase/counter step is one pass of logic between the two registers.
// Reset: synchronous, active high; phase idle, counter cleared, last level
//          released, timing registers back to 50 / 300 / 1000 ticks.
// ----------------------------------------------------------------------------
module button_gesture_detector_unit
   import bgd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // sample channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [0] button_level, [7:1] zero
   // gesture channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [1:0] gesture_event, [7:2] zero
   // timing registers
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_WIDTH-1:0] csr_wdata
);

   cfg_type   cfg;
   event_type gesture;

   logic      in_valid_ff, in_valid_in;
   logic      in_level_ff;
   logic      out_valid_ff, out_valid_in;
   event_type out_event_ff;

   logic      out_free;   // result register can take a new value
   logic      step;       // held sample moves through the machine

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !rsp_tready);

   bgd_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bgd_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step_en (step),
      .level   (in_level_ff),
      .cfg     (cfg),
      .gesture (gesture)
   );

   // handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: sample captured on transfer, gesture captured on step
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_level_ff <= req_tdata[0];
      if (step)                     out_event_ff <= gesture;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_event_ff};

endmodule

// ===== test/button_gesture_detector_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_detector_unit_tb
// Self-checking bench for the button gesture detector. Samples stream in on
// the req_ channel and gesture codes come back on the rsp_ channel. Every
// accepted sample runs through a local model of the phase machine, and the
// predicted code is queued. Each result transfer is checked against the head
// of that queue. Runs cover reset timing, a directed table and randomized
// press/release scripts under several timing settings.
// ----------------------------------------------------------------------------
module button_gesture_detector_unit_tb;
   import bgd_pkg::*;

   // unused register slot, writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam int RANDOM_PHASES   = 4;
   localparam int PHASE_SAMPLES   = 110;
   localparam int DIRECTED_ROWS   = 14;
   // cycles allowed after the last result before the verdict
   localparam int SETTLE_CYCLES   = 8;

   typedef enum logic [1:0] {
      GAP_NONE,
      GAP_FULL,
      GAP_SPARSE
   } gap_mode_type;

   typedef struct packed {
      event_type   ev;
      logic [31:0] seq;
   } gesture_exp_type;

   // one row of the directed table: level, repeat count, typed expectation
   typedef struct packed {
      logic       level;
      logic [7:0] reps;
      logic       typed;
      event_type  ev;
   } script_row_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = 8'd0;   // [0] button_level, [7:1] zero
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;           // [1:0] gesture_event, [7:2] zero
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [REG_WIDTH-1:0] csr_wdata  = '0;

   // model state, mirrors the block after reset
   phase_type            ph_model   = PH_IDLE;
   logic                 long_seen  = 1'b0;
   logic                 prev_level = 1'b1;
   logic [COUNT_WIDTH-1:0] tick_run = '0;
   cfg_type              timing     = '{DEBOUNCE_RST, DOUBLE_RST, LONG_RST};

   gesture_exp_type      gestures_due[$];
   int unsigned          mismatch_count = 0;
   int unsigned          samples_sent   = 0;
   int unsigned          settings_count = 0;
   int unsigned          single_seen    = 0;
   int unsigned          double_seen    = 0;
   int unsigned          long_seen_cnt  = 0;
   gap_mode_type         req_mode       = GAP_FULL;

   // directed timing: debounce 0 (acts as 1), window 2, long press 3
   script_row_type directed [DIRECTED_ROWS] = '{
      '{1'b1, 8'd2, 1'b1, EV_NONE},   // idle, released: nothing
      '{1'b0, 8'd2, 1'b0, EV_NONE},   // press, debounce passes
      '{1'b1, 8'd3, 1'b0, EV_NONE},   // release, window runs out: single
      '{1'b0, 8'd2, 1'b0, EV_NONE},
      '{1'b1, 8'd1, 1'b0, EV_NONE},
      '{1'b0, 8'd1, 1'b0, EV_NONE},   // second press in window: double
      '{1'b0, 8'd1, 1'b0, EV_NONE},   // held low while idle, no edge
      '{1'b1, 8'd1, 1'b0, EV_NONE},   // rising edge in idle is ignored
      '{1'b0, 8'd2, 1'b0, EV_NONE},
      '{1'b0, 8'd3, 1'b0, EV_NONE},   // held to long press
      '{1'b1, 8'd1, 1'b0, EV_NONE},   // release after long press: back to idle
      '{1'b0, 8'd1, 1'b0, EV_NONE},
      '{1'b1, 8'd1, 1'b0, EV_NONE},   // debounce expires released: idle
      '{1'b1, 8'd1, 1'b1, EV_NONE}
   };

   button_gesture_detector_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // --------------------------------------------------------------------------
   // Gesture model: one call per accepted sample.
   // Timer expiry is handled first, then the edge action, then the level is
   // remembered. The tick counter saturates at all ones.
   // --------------------------------------------------------------------------
   function automatic event_type next_gesture(input logic lvl);
      event_type ev;
      ev = EV_NONE;
      if (ph_model != PH_IDLE) begin
         if (tick_run != '1) tick_run = tick_run + 1'b1;
         case (ph_model)
            PH_DEBOUNCE: begin
               if (CMP_WIDTH'(tick_run) >= CMP_WIDTH'(timing.debounce_ticks)) begin
                  if (!lvl) begin
                     ph_model  = PH_PRESSED;
                     long_seen = 1'b0;
                     tick_run  = '0;
                  end else begin
                     ph_model = PH_IDLE;
                  end
               end
            end
            PH_PRESSED: begin
               if (!long_seen &&
                   CMP_WIDTH'(tick_run) >= CMP_WIDTH'(timing.long_press_ticks)) begin
                  long_seen = 1'b1;
                  ev        = EV_LONG;
               end
            end
            default: begin
               if (CMP_WIDTH'(tick_run) >= CMP_WIDTH'(timing.double_click_ticks)) begin
                  ph_model = PH_IDLE;
                  ev       = EV_SINGLE;
               end
            end
         endcase
      end
      // edge actions; edges during debounce are bounce and ignored
      if (lvl != prev_level) begin
         case (ph_model)
            PH_IDLE: begin
               if (!lvl) begin
                  ph_model = PH_DEBOUNCE;
                  tick_run = '0;
               end
            end
            PH_PRESSED: begin
               if (lvl) begin
                  if (!long_seen) begin
                     ph_model = PH_CLICK_WAIT;
                     tick_run = '0;
                  end else begin
                     ph_model = PH_IDLE;
                  end
               end
            end
            PH_CLICK_WAIT: begin
               if (!lvl) begin
                  ph_model = PH_IDLE;
                  ev       = EV_DOUBLE;
               end
            end
            default: ;
         endcase
      end
      prev_level = lvl;
      return ev;
   endfunction

   function automatic int unsigned draw_gap(input gap_mode_type mode);
      case (mode)
         GAP_NONE:   return 0;
         GAP_FULL:   return $urandom_range(0, 18);
         default:    return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
      endcase
   endfunction

   // timing value for a random phase: mostly short, sometimes zero, one or max
   function automatic logic [REG_WIDTH-1:0] pick_ticks(input int unsigned hi);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return REG_WIDTH'(1);
         2:       return '1;
         default: return REG_WIDTH'($urandom_range(1, hi));
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // --------------------------------------------------------------------------
   // Sample sender. valid stays high across back-to-back transfers; it is only
   // lowered when this item draws a gap, so it never gets two updates per step.
   // --------------------------------------------------------------------------
   task automatic send_sample(input logic lvl, input logic typed, input event_type typed_ev);
      int unsigned     gap;
      event_type       pred;
      gesture_exp_type item;
      gap = draw_gap(req_mode);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, lvl};
      do @(posedge clock); while (!req_tready);
      pred      = next_gesture(lvl);
      item.ev   = typed ? typed_ev : pred;
      item.seq  = samples_sent;
      gestures_due.push_back(item);
      samples_sent++;
   endtask

   task automatic drive_level(input logic lvl, input int unsigned reps);
      repeat (reps) send_sample(lvl, 1'b0, EV_NONE);
   endtask

   // stop offering and wait until every queued gesture has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (gestures_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [REG_WIDTH-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_DEBOUNCE: timing.debounce_ticks     = val;
         CSR_DOUBLE:   timing.double_click_ticks = val;
         CSR_LONG:     timing.long_press_ticks   = val;
         default:      ;
      endcase
   endtask

   // all three timers plus a junk write to the spare slot; only while drained
   task automatic program_timing(input logic [REG_WIDTH-1:0] db,
                                 input logic [REG_WIDTH-1:0] dc,
                                 input logic [REG_WIDTH-1:0] lp);
      write_csr(CSR_DEBOUNCE, db);
      write_csr(CSR_DOUBLE, dc);
      write_csr(CSR_LONG, lp);
      write_csr(CSR_SPARE, REG_WIDTH'($urandom_range(0, 65535)));
      csr_we <= 1'b0;
      @(posedge clock);
      settings_count++;
   endtask

   // --------------------------------------------------------------------------
   // Result checker: every rsp transfer is matched against the oldest entry.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      gesture_exp_type head;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (gestures_due.size() == 0) begin
            report_mismatch($sformatf("gesture 0x%02h with no sample pending", rsp_tdata));
         end else begin
            head = gestures_due.pop_front();
            if (rsp_tdata[1:0] !== head.ev)
               report_mismatch($sformatf("sample %0d: gesture_event %0d, want %0d",
                                         head.seq, rsp_tdata[1:0], head.ev));
            if (rsp_tdata[7:2] !== 6'd0)
               report_mismatch($sformatf("sample %0d: pad bits 0x%02h not zero",
                                         head.seq, rsp_tdata[7:2]));
            case (rsp_tdata[1:0])
               EV_SINGLE: single_seen++;
               EV_DOUBLE: double_seen++;
               EV_LONG:   long_seen_cnt++;
               default:   ;
            endcase
         end
      end
   end

   // --------------------------------------------------------------------------
   // Result receiver: random ready gaps and two long holds to back the block
   // up into its input.
   // --------------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned  gap;
      int unsigned  taken;
      int unsigned  hold;
      gap_mode_type rsp_mode;
      taken    = 0;
      rsp_mode = GAP_FULL;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 128 == 0) rsp_mode = gap_mode_type'($urandom_range(0, 2));
         hold = (taken == 400 || taken == 1600) ? 150 : 0;
         gap  = draw_gap(rsp_mode) + hold;
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   initial begin : req_side
      logic        cur_level;
      int unsigned phase_start;
      int unsigned press_span;
      int unsigned release_span;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset timing 50 / 300 / 1000: one single click, then one long press
      req_mode = GAP_SPARSE;
      drive_level(1'b1, 3);
      drive_level(1'b0, 60);
      drive_level(1'b1, 305);
      drive_level(1'b0, 1060);
      drive_level(1'b1, 5);
      drain_results();

      // directed table
      program_timing(16'd0, 16'd2, 16'd3);
      req_mode = GAP_FULL;
      foreach (directed[r])
         repeat (directed[r].reps)
            send_sample(directed[r].level, directed[r].typed, directed[r].ev);

      // random phases: mostly press/release scripts around the timer values
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_results();
         program_timing(pick_ticks(8), pick_ticks(12), pick_ticks(16));
         req_mode     = gap_mode_type'($urandom_range(0, 2));
         press_span   = ((timing.debounce_ticks > 40) ? 40 : timing.debounce_ticks) +
                        ((timing.long_press_ticks > 40) ? 40 : timing.long_press_ticks) + 4;
         release_span = ((timing.double_click_ticks > 40) ? 40 : timing.double_click_ticks) + 4;
         phase_start  = samples_sent;
         while (samples_sent - phase_start < PHASE_SAMPLES) begin
            case ($urandom_range(0, 9))
               0: begin
                  // noise
                  repeat (6) send_sample(1'($urandom_range(0, 1)), 1'b0, EV_NONE);
               end
               1: begin
                  // bounce: single-tick alternations starting low
                  cur_level = 1'b0;
                  repeat ($urandom_range(2, 8)) begin
                     send_sample(cur_level, 1'b0, EV_NONE);
                     cur_level = ~cur_level;
                  end
               end
               default: begin
                  drive_level(1'b0, $urandom_range(1, press_span));
                  drive_level(1'b1, $urandom_range(1, release_span));
               end
            endcase
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d samples under %0d timing settings plus reset timing", samples_sent,
               settings_count);
      $display("gestures seen: %0d single, %0d double, %0d long press", single_seen,
               double_seen, long_seen_cnt);
      if (mismatch_count == 0) begin
         $display("button_gesture_detector_unit_tb: clean");
      end else begin
         $display("button_gesture_detector_unit_tb: errors");
      end
      $finish;
   end

   // run limit, several times the slowest legal run
   initial begin : watchdog
      #20ms;
      $display("timeout with %0d gestures outstanding", gestures_due.size());
      $display("button_gesture_detector_unit_tb: errors");
      $finish;
   end

endmodule
